### sv/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the RMS meter RTL.
// Depends on nothing; each macro takes a label, clock, active-low reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define BRMS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("%m: assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define BRMS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

`endif

### sv/brms_pkg.sv
// brms_pkg: widths, step counts and the shared-unit opcode for the block RMS meter.
// Used by brms_iter_unit and block_rms_meter; depends on nothing.
package brms_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_BLOCK   = 65536;
	localparam int LEVEL_W     = 24;

	// Square and accumulator widths
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int SUM_W = 63;
	localparam int CNT_W = $clog2(MAX_BLOCK + 1);

	// Divide and square-root datapath
	localparam int DIV_STEPS = SUM_W;
	localparam int RAD_W     = 2 * ((SUM_W + 1) / 2);
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int TRY_W     = REM_W + 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Commands to the shared compare-subtract unit
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD_DIV,
		OP_DIV_STEP,
		OP_LOAD_SQRT,
		OP_SQRT_STEP
	} brms_op_t;

endpackage

### sv/brms_iter_unit.sv
// brms_iter_unit: one compare-subtract unit that runs a restoring divide (one quotient
// bit per step) and then a digit-by-digit square root (one root bit per step).
// Depends on brms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module brms_iter_unit
	import brms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  brms_op_t           op,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [CNT_W-1:0]   divisor,
	output logic [LEVEL_W-1:0] root
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_DIV,
		M_SQRT
	} mode_t;

	mode_t              mode_q;
	logic [RAD_W-1:0]   shift_q;
	logic [REM_W-1:0]   rem_q;
	logic [ROOT_W-1:0]  root_q;
	logic [CNT_W-1:0]   divisor_q;

	logic [TRY_W-1:0]   opa;
	logic [TRY_W-1:0]   opb;
	logic [TRY_W:0]     diff;
	logic               ge;
	logic [REM_W-1:0]   root_x2;

	// Operand select for the shared subtractor
	always_comb begin
		if (op == OP_SQRT_STEP) begin
			opa = {rem_q, shift_q[RAD_W-1 -: 2]};
			opb = {1'b0, root_q, 2'b01};
		end else begin
			opa = TRY_W'({rem_q[CNT_W-1:0], shift_q[SUM_W-1]});
			opb = TRY_W'(divisor_q);
		end
		diff = {1'b0, opa} - {1'b0, opb};
		ge   = !diff[TRY_W];
	end

	assign root_x2 = {root_q, 1'b0};
	assign root    = root_q[LEVEL_W-1:0];

	// Mode tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
		end else if (op == OP_LOAD_DIV) begin
			mode_q <= M_DIV;
		end else if (op == OP_LOAD_SQRT) begin
			mode_q <= M_SQRT;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_NONE: begin
			end
			OP_LOAD_DIV: begin
				shift_q   <= RAD_W'(dividend);
				divisor_q <= divisor;
				rem_q     <= '0;
			end
			OP_DIV_STEP: begin
				// dividend bits leave at the top, quotient bits enter at the bottom
				rem_q   <= ge ? REM_W'(diff[CNT_W-1:0]) : REM_W'(opa[CNT_W-1:0]);
				shift_q <= {shift_q[RAD_W-2:0], ge};
			end
			OP_LOAD_SQRT: begin
				shift_q <= RAD_W'(shift_q[SUM_W-1:0]);
				rem_q   <= '0;
				root_q  <= '0;
			end
			OP_SQRT_STEP: begin
				rem_q   <= ge ? diff[REM_W-1:0] : opa[REM_W-1:0];
				shift_q <= shift_q << 2;
				root_q  <= {root_q[ROOT_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	`BRMS_ASSERT_IMPL(a_div_rem_bound, clk, arst_n, mode_q == M_DIV, rem_q < REM_W'(divisor_q))
	`BRMS_ASSERT_IMPL(a_sqrt_rem_bound, clk, arst_n, mode_q == M_SQRT, rem_q <= root_x2)

endmodule

### sv/block_rms_meter.sv
// block_rms_meter: block RMS level meter with sample pass-through (top level).
// Depends on brms_pkg, brms_iter_unit and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per audio sample:
//   sample_in (signed Q1.23) and block_end. Output channel (out_valid/out_stall)
//   returns one transaction per input: the sample unchanged, the held RMS level
//   (unsigned Q1.23) and rms_updated, set when that sample closed a block.
//   A block closes on block_end or when it reaches MAX_BLOCK samples; the level
//   becomes floor(sqrt(floor(sum of squares / count))).
//   A sample that does not close a block passes S_SQUARE, S_ACCUM and S_DONE
//   before it reaches the output register; a closing sample passes S_DIV,
//   S_SQLOAD and S_SQRT between S_ACCUM and S_DONE: 63 divide steps and 32
//   square-root steps through the one shared subtractor. One transaction is in
//   flight at a time; in_stall is high from acceptance until the result is loaded
//   into the output register, so no new sample is accepted before then.
//   A stalled output holds its transaction; the next one waits in its final state.
//   Reset clears the accumulator, the sample count and the held level to zero.
`include "assert_macros.svh"

module block_rms_meter
	import brms_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [LEVEL_W-1:0]            rms_level,
	output logic                          rms_updated
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_ACCUM,
		S_DIV,
		S_SQLOAD,
		S_SQRT,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   mark_q;
	logic [SQ_W-1:0]        sq_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       count_q;
	logic                   close_q;
	logic [STEP_W-1:0]      step_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] sample_out_q;
	logic [LEVEL_W-1:0]     rms_level_q;
	logic                   rms_updated_q;

	logic [SAMPLE_BITS-1:0] mag;
	logic [SUM_W:0]         sum_ext;
	logic [SUM_W-1:0]       sum_next;
	logic [CNT_W-1:0]       count_next;
	logic                   close_now;
	brms_op_t               op;
	logic [LEVEL_W-1:0]     root;
	logic                   accept;
	logic                   out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Magnitude, saturating accumulate and block-close decision
	always_comb begin
		mag        = sample_q[SAMPLE_BITS-1] ? (~sample_q + 1'b1) : sample_q;
		sum_ext    = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
		sum_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		count_next = count_q + 1'b1;
		close_now  = mark_q || (count_next >= CNT_W'(MAX_BLOCK));
	end

	// Commands to the shared unit
	always_comb begin
		unique case (state_q)
			S_ACCUM:  op = close_now ? OP_LOAD_DIV : OP_NONE;
			S_DIV:    op = OP_DIV_STEP;
			S_SQLOAD: op = OP_LOAD_SQRT;
			S_SQRT:   op = OP_SQRT_STEP;
			default:  op = OP_NONE;
		endcase
	end

	brms_iter_unit u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.dividend (sum_next),
		.divisor  (count_next),
		.root     (root)
	);

	// Sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			sum_q         <= '0;
			count_q       <= '0;
			close_q       <= 1'b0;
			step_q        <= '0;
			out_valid_q   <= 1'b0;
			rms_level_q   <= '0;
			rms_updated_q <= 1'b0;
		end else begin
			// S_DONE reloads the output register itself
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SQUARE;
					end
				end
				S_SQUARE: begin
					state_q <= S_ACCUM;
				end
				S_ACCUM: begin
					close_q <= close_now;
					step_q  <= '0;
					if (close_now) begin
						sum_q   <= '0;
						count_q <= '0;
						state_q <= S_DIV;
					end else begin
						sum_q   <= sum_next;
						count_q <= count_next;
						state_q <= S_DONE;
					end
				end
				S_DIV: begin
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= S_SQLOAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_SQLOAD: begin
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						step_q  <= '0;
						state_q <= S_DONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						rms_updated_q <= close_q;
						if (close_q) begin
							rms_level_q <= root;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_in;
			mark_q   <= block_end;
		end
		if (state_q == S_SQUARE) begin
			sq_q <= mag * mag;
		end
		if (state_q == S_DONE && out_free) begin
			sample_out_q <= sample_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = $signed(sample_out_q);
	assign rms_level   = rms_level_q;
	assign rms_updated = rms_updated_q;

	`BRMS_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q < CNT_W'(MAX_BLOCK))
	`BRMS_ASSERT_IMPL(a_cleared_in_div, clk, arst_n, state_q == S_DIV, (sum_q == '0) && (count_q == '0))
	`BRMS_ASSERT_IMPL(a_level_range, clk, arst_n, out_valid_q, rms_level_q <= LEVEL_W'(1 << (LEVEL_W - 1)))

endmodule

### tb/block_rms_meter_tb.sv
// block_rms_meter_tb: self-checking testbench for the block RMS level meter.
// Drives samples through a directed table and random blocks, and checks each
// output transaction against a local model or the directed table. Depends on brms_pkg and block_rms_meter.
module block_rms_meter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import brms_pkg::*;

	localparam int     RANDOM_ITEMS = 1250;
	localparam int     QUIET_TAIL   = 150;
	localparam int     LONG_HOLD    = 300;
	localparam int     DRAIN_CYCLES = 120;
	// Watchdog budget for under 1.5k transactions, including stalls, with a wide margin
	localparam longint CYCLE_LIMIT  = 1_000_000;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// One output transaction as the meter should report it
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pcm;
		logic [LEVEL_W-1:0]            level;
		logic                          closed;
	} reading_t;

	// Directed row; level/closed are only used when typed is set
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pcm;
		logic                          mark;
		logic                          typed;
		logic [LEVEL_W-1:0]            level;
		logic                          closed;
	} dir_row_t;

	localparam int DIR_COUNT = 18;
	localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
		// right after reset the level reads zero
		'{24'h000000, 1'b0, 1'b1, 24'h000000, 1'b0},
		// block of zeros closes at zero
		'{24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1},
		// single negative full-scale sample: rms is exactly 1.0
		'{24'h800000, 1'b1, 1'b1, 24'h800000, 1'b1},
		// single positive full-scale sample
		'{24'h7FFFFF, 1'b1, 1'b1, 24'h7FFFFF, 1'b1},
		// level holds while a block is open
		'{24'h000001, 1'b0, 1'b1, 24'h7FFFFF, 1'b0},
		'{24'hFFFFFF, 1'b1, 1'b1, 24'h000001, 1'b1},
		// (9 + 16) / 2 truncates, root truncates
		'{24'h000003, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'h000004, 1'b1, 1'b0, 24'h000000, 1'b0},
		// mean of one half truncates to zero
		'{24'h000001, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1},
		// alternating extremes
		'{24'h7FFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'h800000, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'h7FFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'h800000, 1'b1, 1'b0, 24'h000000, 1'b0},
		// checkerboard bit patterns
		'{24'h555555, 1'b0, 1'b0, 24'h000000, 1'b0},
		'{24'hAAAAAA, 1'b1, 1'b0, 24'h000000, 1'b0},
		'{24'hAAAAAA, 1'b1, 1'b0, 24'h000000, 1'b0},
		'{24'h555555, 1'b1, 1'b0, 24'h000000, 1'b0}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          block_end;
	logic                          out_valid;
	logic                          out_stall;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [LEVEL_W-1:0]            rms_level;
	logic                          rms_updated;

	// Local copy of the meter state
	logic [SUM_W-1:0]   acc_sum;
	logic [CNT_W-1:0]   acc_count;
	logic [LEVEL_W-1:0] acc_level;

	reading_t readings_due [$];
	int       fail_count   = 0;
	int       tx_pct       = 0;
	int       rx_pct       = 0;
	bit       hold_off_req = 1'b0;
	longint   cycles       = 0;

	block_rms_meter u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bitwise floor square root, one result bit per pass
	function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= v)
				root = trial;
		end
		return root;
	endfunction

	// Accumulate one sample, close the block on a mark or a full count
	function automatic reading_t accumulate_sample(input logic signed [SAMPLE_BITS-1:0] pcm,
			input logic mark);
		logic [SAMPLE_BITS-1:0] mag;
		logic [SQ_W-1:0]        sq;
		logic [SUM_W:0]         total;
		logic [31:0]            root;
		reading_t               r;
		mag   = pcm[SAMPLE_BITS-1] ? (~pcm + 1'b1) : pcm;
		sq    = SQ_W'(mag) * SQ_W'(mag);
		total = {1'b0, acc_sum} + (SUM_W + 1)'(sq);
		acc_sum   = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_W-1:0];
		acc_count = acc_count + 1'b1;
		r.closed  = 1'b0;
		if (mark || acc_count >= MAX_BLOCK) begin
			root      = floor_sqrt(64'(acc_sum / acc_count));
			acc_level = root[LEVEL_W-1:0];
			acc_sum   = '0;
			acc_count = '0;
			r.closed  = 1'b1;
		end
		r.pcm   = pcm;
		r.level = acc_level;
		return r;
	endfunction

	// Sample mix: full range, near zero, rails, near the rails, silence
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		unique case ($urandom_range(0, 5))
			0, 1: return SAMPLE_BITS'($urandom);
			2: return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
			3: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			4: return $urandom_range(0, 1) ? 24'h7FFFFF - 24'($urandom_range(0, 65535))
				: 24'h800000 + 24'($urandom_range(0, 65535));
			default: return '0;
		endcase
	endfunction

	function automatic int pick_idle();
		unique case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	// Offer one sample, wait for the transaction, then queue the expected reading
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] pcm, input logic mark,
			input logic typed, input logic [LEVEL_W-1:0] level, input logic closed);
		reading_t r;
		if (tx_pct != 0 && $urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= pcm;
		block_end <= mark;
		do @(posedge clk); while (in_stall);
		r = accumulate_sample(pcm, mark);
		if (typed) begin
			r.level  = level;
			r.closed = closed;
		end
		readings_due.push_back(r);
	endtask

	// Stop offering until every queued reading has come back
	task automatic drain_outputs();
		in_valid <= 1'b0;
		do @(posedge clk); while (readings_due.size() != 0);
	endtask

	task automatic compare_field(input string what, input logic [SAMPLE_BITS-1:0] want,
			input logic [SAMPLE_BITS-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	task automatic check_reading();
		reading_t want;
		if (readings_due.size() == 0) begin
			$display("%0t: unexpected transaction: expected none, actual %h/%h/%b",
				$time, sample_out, rms_level, rms_updated);
			fail_count++;
			return;
		end
		want = readings_due.pop_front();
		compare_field("sample_out", want.pcm, sample_out);
		compare_field("rms_level", want.level, rms_level);
		compare_field("rms_updated", SAMPLE_BITS'(want.closed), SAMPLE_BITS'(rms_updated));
	endtask

	// Output side: check accepted transactions, stall in bursts or on a long hold
	initial begin
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				check_reading();
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = LONG_HOLD;
			end else if (hold == 0 && rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
				hold = $urandom_range(1, 7);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Stimulus
	initial begin
		int n;
		int len;
		bit noisy;
		logic mark;
		acc_sum   = '0;
		acc_count = '0;
		acc_level = '0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		sample_in <= '0;
		block_end <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the last row closes a block
		tx_pct = 20;
		rx_pct = 20;
		for (int i = 0; i < DIR_COUNT; i++)
			send_sample(DIR_ROWS[i].pcm, DIR_ROWS[i].mark, DIR_ROWS[i].typed,
				DIR_ROWS[i].level, DIR_ROWS[i].closed);
		drain_outputs();

		// random blocks, mostly well formed, some with stray or missing marks
		n = 0;
		while (n < RANDOM_ITEMS) begin
			if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
				tx_pct = 0;
				rx_pct = 0;
			end else begin
				tx_pct = pick_idle();
				rx_pct = pick_idle();
			end
			len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
			noisy = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++) begin
				mark = noisy ? ($urandom_range(0, 3) == 0) : (i == len - 1);
				send_sample(pick_sample(), mark, 1'b0, '0, 1'b0);
				n++;
				// output held off while samples keep coming
				if (n == 400)
					hold_off_req = 1'b1;
			end
		end

		drain_outputs();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### sim.f
+incdir+sv
sv/brms_pkg.sv
sv/brms_iter_unit.sv
sv/block_rms_meter.sv
tb/block_rms_meter_tb.sv
